@@ rtl/plr_pkg.sv @@
// Shared types and constants for the program driven line resampler.
// Holds opcode codes, fixed field widths and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plr_pkg;

    // Fixed widths of the item fields.
    localparam int COLOR_W = 4;
    localparam int DEST_W  = 10;
    localparam int PTR_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    // Program storage is always 22 bytes wide (three registers).
    localparam int STORE_BYTES = 22;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_HI  = 2'd2;

    // Program byte values as read from storage.
    localparam logic [BYTE_W-1:0] BYTE_RESTART = 8'd0;
    localparam logic [BYTE_W-1:0] BYTE_COPY    = 8'd1;
    localparam logic [BYTE_W-1:0] BYTE_REPL    = 8'd2;
    localparam logic [BYTE_W-1:0] BYTE_SKIP    = 8'd3;
    localparam logic [BYTE_W-1:0] HALF_SCALE_MIN = 8'd4;

    // Active operation codes held between items.
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_COPY = 2'd1;
    localparam logic [1:0] OP_REPL = 2'd2;
    localparam logic [1:0] OP_SKIP = 2'd3;

    localparam logic [DEST_W-1:0] DEST_MAX = 10'd1023;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch the accepted item, apply line start
        logic half_step;   // toggle unit parity in half-scale mode
        logic count_step;  // consume one unit of the active copy or skip
        logic clear_op;    // drop any finished operation
        logic set_error;   // fetch limit hit: set the sticky error
        logic fetch_op;    // fetch an opcode byte
        logic fetch_arg;   // fetch an operand byte
        logic set_single;  // one result to emit
        logic emit;        // load the output register with one result
    } plr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic half_mode;
        logic parity_odd;
        logic copy_active;
        logic skip_active;
        logic fetch_limit;
        logic byte_has_arg;   // current byte is copy, skip or replicate
        logic arg_repl;       // latched opcode is replicate
        logic byte_zero;      // current byte is zero
        logic rep_last;       // one result left to emit
        logic out_free;       // output register can take a result
    } plr_status_t;

endpackage

`default_nettype wire

@@ rtl/plr_ctrl.sv @@
// Sequencing state machine of the line resampler.
// Depends on plr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module plr_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire plr_pkg::plr_status_t status,
    output plr_pkg::plr_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DISPATCH  = 3'd1;
    localparam logic [2:0] ST_FETCH_OP  = 3'd2;
    localparam logic [2:0] ST_FETCH_ARG = 3'd3;
    localparam logic [2:0] ST_EMIT      = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.half_mode)
                begin
                    cmd.half_step = 1'b1;
                    if (!status.parity_odd)
                    begin
                        cmd.set_single = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (status.copy_active)
                begin
                    cmd.count_step = 1'b1;
                    cmd.set_single = 1'b1;
                    state_next     = ST_EMIT;
                end
                else if (status.skip_active)
                begin
                    cmd.count_step = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.clear_op = 1'b1;
                    if (status.fetch_limit)
                    begin
                        cmd.set_error = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FETCH_OP;
                    end
                end
            end
            ST_FETCH_OP:
            begin
                cmd.fetch_op = 1'b1;
                state_next   = status.byte_has_arg ? ST_FETCH_ARG : ST_DISPATCH;
            end
            ST_FETCH_ARG:
            begin
                cmd.fetch_arg = 1'b1;
                if (status.arg_repl)
                begin
                    state_next = status.byte_zero ? ST_IDLE : ST_EMIT;
                end
                else
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.rep_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/plr_datapath.sv @@
// Datapath of the line resampler: program storage, pointer, counters and output register.
// Depends on plr_pkg for constants and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module plr_datapath
#(
    parameter int PROGRAM_BYTES = 22,
    parameter int MAX_REPLICATE = 64,
    parameter int MAX_FETCHES   = 44
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire plr_pkg::plr_cmd_t                   cmd,
    output plr_pkg::plr_status_t                     status,
    input  wire logic                                cfg_write,
    input  wire logic [plr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [plr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [plr_pkg::COLOR_W-1:0]         in_color,
    input  wire logic                                in_line_start,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [plr_pkg::COLOR_W-1:0]              out_color,
    output logic [plr_pkg::DEST_W-1:0]               out_dest,
    output logic                                     out_last,
    output logic                                     out_error
);

    localparam int FCNT_W = $clog2(MAX_FETCHES + 2);
    localparam int REP_W  = $clog2(MAX_REPLICATE + 1);
    localparam int HI_W   = (plr_pkg::STORE_BYTES - 16) * plr_pkg::BYTE_W;

    // Program registers.
    logic [63:0]     prog_lo_reg;
    logic [63:0]     prog_mid_reg;
    logic [HI_W-1:0] prog_hi_reg;

    // Walk state.
    logic [plr_pkg::PTR_W-1:0]   ptr_reg,    ptr_next;
    logic [1:0]                  op_reg,     op_next;
    logic [1:0]                  fop_reg,    fop_next;
    logic [7:0]                  rem_reg,    rem_next;
    logic [plr_pkg::DEST_W-1:0]  dest_reg,   dest_next;
    logic                        parity_reg, parity_next;
    logic                        error_reg,  error_next;
    logic [FCNT_W-1:0]           fcnt_reg,   fcnt_next;
    logic [REP_W-1:0]            rep_reg,    rep_next;
    logic [plr_pkg::COLOR_W-1:0] color_reg,  color_next;

    // Output register.
    logic                        ovalid_reg, ovalid_next;
    logic [plr_pkg::COLOR_W-1:0] ocolor_reg, ocolor_next;
    logic [plr_pkg::DEST_W-1:0]  odest_reg,  odest_next;
    logic                        olast_reg,  olast_next;
    logic                        oerr_reg,   oerr_next;

    logic [plr_pkg::BYTE_W-1:0]  prog_byte_w [plr_pkg::STORE_BYTES];
    logic [plr_pkg::BYTE_W-1:0]  cur_byte;
    logic [plr_pkg::PTR_W-1:0]   ptr_inc;
    logic [plr_pkg::PTR_W-1:0]   ptr_wrap;
    logic [REP_W-1:0]            rep_clamp;
    logic                        out_free;

    // Byte view of the program registers.
    always_comb
    begin
        for (int i = 0; i < plr_pkg::STORE_BYTES; i++)
        begin
            if (i < 8)
            begin
                prog_byte_w[i] = prog_lo_reg[i*8 +: 8];
            end
            else if (i < 16)
            begin
                prog_byte_w[i] = prog_mid_reg[(i-8)*8 +: 8];
            end
            else
            begin
                prog_byte_w[i] = prog_hi_reg[(i-16)*8 +: 8];
            end
        end
    end

    assign cur_byte = (ptr_reg < plr_pkg::PTR_W'(plr_pkg::STORE_BYTES)) ?
                      prog_byte_w[ptr_reg] : '0;

    // Pointer advance with wrap at the program length.
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_wrap = (ptr_inc >= plr_pkg::PTR_W'(PROGRAM_BYTES)) ? '0 : ptr_inc;

    // Replicate count clamped to its ceiling.
    assign rep_clamp = (cur_byte > 8'(MAX_REPLICATE)) ? REP_W'(MAX_REPLICATE)
                                                      : REP_W'(cur_byte);

    assign out_free = !ovalid_reg || out_ready;

    // Status toward the controller.
    always_comb
    begin
        status              = '0;
        status.half_mode    = (prog_byte_w[0] >= plr_pkg::HALF_SCALE_MIN);
        status.parity_odd   = parity_reg;
        status.copy_active  = (rem_reg != 8'd0) && (op_reg == plr_pkg::OP_COPY);
        status.skip_active  = (rem_reg != 8'd0) && (op_reg == plr_pkg::OP_SKIP);
        status.fetch_limit  = (fcnt_reg >= FCNT_W'(MAX_FETCHES));
        status.byte_has_arg = (cur_byte == plr_pkg::BYTE_COPY) ||
                              (cur_byte == plr_pkg::BYTE_SKIP) ||
                              (cur_byte == plr_pkg::BYTE_REPL);
        status.arg_repl     = (fop_reg == plr_pkg::OP_REPL);
        status.byte_zero    = (cur_byte == 8'd0);
        status.rep_last     = (rep_reg == REP_W'(1));
        status.out_free     = out_free;
    end

    // Next-state logic of the walk and output registers.
    always_comb
    begin
        ptr_next    = ptr_reg;
        op_next     = op_reg;
        fop_next    = fop_reg;
        rem_next    = rem_reg;
        dest_next   = dest_reg;
        parity_next = parity_reg;
        error_next  = error_reg;
        fcnt_next   = fcnt_reg;
        rep_next    = rep_reg;
        color_next  = color_reg;
        ovalid_next = ovalid_reg;
        ocolor_next = ocolor_reg;
        odest_next  = odest_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cmd.load)
        begin
            color_next = in_color;
            fcnt_next  = '0;
            if (in_line_start)
            begin
                ptr_next    = '0;
                op_next     = plr_pkg::OP_NONE;
                rem_next    = 8'd0;
                dest_next   = '0;
                parity_next = 1'b0;
            end
        end

        if (cmd.half_step)
        begin
            parity_next = !parity_reg;
        end

        if (cmd.count_step)
        begin
            rem_next = rem_reg - 8'd1;
            if (rem_reg == 8'd1)
            begin
                op_next = plr_pkg::OP_NONE;
            end
        end

        if (cmd.clear_op)
        begin
            op_next  = plr_pkg::OP_NONE;
            rem_next = 8'd0;
        end

        if (cmd.set_error)
        begin
            error_next = 1'b1;
        end

        if (cmd.set_single)
        begin
            rep_next = REP_W'(1);
        end

        // Opcode fetch: a restart byte sends the pointer back to byte zero.
        if (cmd.fetch_op)
        begin
            fcnt_next = fcnt_reg + 1'b1;
            fop_next  = cur_byte[1:0];
            ptr_next  = (cur_byte == plr_pkg::BYTE_RESTART) ? '0 : ptr_wrap;
        end

        // Operand fetch: starts a copy or skip run, or sets a replicate count.
        if (cmd.fetch_arg)
        begin
            fcnt_next = fcnt_reg + 1'b1;
            ptr_next  = ptr_wrap;
            if (fop_reg == plr_pkg::OP_REPL)
            begin
                rep_next = rep_clamp;
            end
            else
            begin
                rem_next = cur_byte;
                op_next  = (cur_byte != 8'd0) ? fop_reg : plr_pkg::OP_NONE;
            end
        end

        // One result into the output register; the position saturates.
        if (cmd.emit)
        begin
            ovalid_next = 1'b1;
            ocolor_next = color_reg;
            odest_next  = dest_reg;
            olast_next  = (rep_reg == REP_W'(1));
            oerr_next   = error_reg;
            rep_next    = rep_reg - 1'b1;
            if (dest_reg < plr_pkg::DEST_MAX)
            begin
                dest_next = dest_reg + 1'b1;
            end
        end
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_lo_reg  <= '0;
            prog_mid_reg <= '0;
            prog_hi_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                plr_pkg::CFG_PROG_LO:  prog_lo_reg  <= cfg_data;
                plr_pkg::CFG_PROG_MID: prog_mid_reg <= cfg_data;
                plr_pkg::CFG_PROG_HI:  prog_hi_reg  <= cfg_data[HI_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            op_reg     <= plr_pkg::OP_NONE;
            rem_reg    <= 8'd0;
            dest_reg   <= '0;
            parity_reg <= 1'b0;
            error_reg  <= 1'b0;
            fcnt_reg   <= '0;
            rep_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            op_reg     <= op_next;
            rem_reg    <= rem_next;
            dest_reg   <= dest_next;
            parity_reg <= parity_next;
            error_reg  <= error_next;
            fcnt_reg   <= fcnt_next;
            rep_reg    <= rep_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fop_reg    <= fop_next;
        color_reg  <= color_next;
        ocolor_reg <= ocolor_next;
        odest_reg  <= odest_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
    end

    assign out_valid = ovalid_reg;
    assign out_color = ocolor_reg;
    assign out_dest  = odest_reg;
    assign out_last  = olast_reg;
    assign out_error = oerr_reg;

`ifndef SYNTHESIS
    // A result is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded over a pending result");

    // The pointer stays inside the program.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg < plr_pkg::PTR_W'(PROGRAM_BYTES))
        else $error("byte pointer beyond program length");

    // The fetch count overshoots the limit by at most one operand byte.
    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCNT_W'(MAX_FETCHES + 1))
        else $error("fetch counter beyond limit");

    // Pending result count never exceeds the replicate ceiling.
    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg <= REP_W'(MAX_REPLICATE))
        else $error("replicate count beyond ceiling");

    // The error flag is sticky.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("sticky error cleared");
`endif

endmodule

`default_nettype wire

@@ rtl/program_driven_line_resampler_core.sv @@
// Top level of the program driven line resampler.
// Instantiates plr_ctrl and plr_datapath; uses plr_pkg for shared types.
//
// Channel  Direction  Handshake                Payload
// s_*      in         s_tvalid / s_tready      tdata: pixel_color; tuser: line_start
// m_*      out        m_tvalid / m_tready      tdata: out_color, dest_index;
//                                              tlast: last_of_run; tuser: program_error
// cfg_*    in         cfg_valid / cfg_ready    cfg_index, cfg_data (program registers)
//
// One item at a time: the item is accepted, then each opcode pass has a dispatch step
// and a fetch per program byte (up to MAX_FETCHES plus one operand before a drop).
// A copied unit gives one result and a skipped unit none; a replicate of n gives one
// result per cycle while the output register is free.
// The output register lets the next item be accepted while a result waits.
// rst_n is asynchronous; configuration is taken every cycle, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module program_driven_line_resampler_core
#(
    parameter int PROGRAM_BYTES = 22,
    parameter int MAX_REPLICATE = 64,
    parameter int MAX_FETCHES   = 44
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] pixel_color, [7:4] zero
    input  wire logic        s_tuser,   // [0] line_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [3:0] out_color, [13:4] dest_index, [15:14] zero
    output logic             m_tlast,   // last_of_run
    output logic             m_tuser,   // [0] program_error
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    plr_pkg::plr_cmd_t    cmd;
    plr_pkg::plr_status_t status;

    logic [plr_pkg::COLOR_W-1:0] out_color;
    logic [plr_pkg::DEST_W-1:0]  out_dest;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;

    plr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plr_datapath
    #(
        .PROGRAM_BYTES (PROGRAM_BYTES),
        .MAX_REPLICATE (MAX_REPLICATE),
        .MAX_FETCHES   (MAX_FETCHES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_color      (s_tdata[3:0]),
        .in_line_start (s_tuser),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_color     (out_color),
        .out_dest      (out_dest),
        .out_last      (m_tlast),
        .out_error     (m_tuser)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {2'b00, out_dest, out_color};

endmodule

`default_nettype wire
